FILE: rtl/core/rra_pkg.sv
// Shared types and constants for the round-robin slot allocator.
// Used by rra_ctrl, rra_dp and the top level; depends on nothing else.
package rra_pkg;

    localparam int POOL_UNITS_DEF       = 16;
    localparam int OBJECT_SLOTS_DEF     = 8;
    localparam int UNITS_PER_OBJECT_DEF = 4;

    localparam int UNIT_W    = 6;   // reported unit number width
    localparam int CNT_W     = 3;   // unit count width
    localparam int SLOT_IN_W = 3;   // slot field width on the ports
    localparam int OUT_UNITS = 4;   // unit fields in one result

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code              command;
        logic [CNT_W-1:0]       unit_count;
        logic [SLOT_IN_W-1:0]   slot_index;
    } t_in;

    typedef struct packed {
        logic                   success;
        logic [SLOT_IN_W-1:0]   slot_number;
        logic [CNT_W-1:0]       units_valid;
        logic [UNIT_W-1:0]      unit_a;
        logic [UNIT_W-1:0]      unit_b;
        logic [UNIT_W-1:0]      unit_c;
        logic [UNIT_W-1:0]      unit_d;
    } t_out;

    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_FAIL = 2'd1,
        RES_NONE = 2'd2
    } t_res_kind;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_SCAN      = 3'd1,
        ST_PROBE     = 3'd2,
        ST_COMMIT    = 3'd3,
        ST_FREE_CHK  = 3'd4,
        ST_FREE_TAKE = 3'd5,
        ST_FREE_RD   = 3'd6,
        ST_FINISH    = 3'd7
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      scan_step;
        logic      probe;
        logic      rollback;
        logic      mem_wr;
        logic      free_take;
        logic      finish;
        t_res_kind res;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_free;
        logic scan_last;
        logic req_zero;
        logic probe_hit;
        logic probe_last;
        logic alloc_k_last;
        logic commit_last;
        logic free_ok;
        logic free_k_last;
    } t_dp_stat;

endpackage

FILE: rtl/core/rra_ctrl.sv
// Controller state machine for the round-robin slot allocator.
// Depends on rra_pkg for the state, command and status types.
module rra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rra_pkg::t_cmd_code  i_command,
    input  rra_pkg::t_dp_stat   i_stat,
    output rra_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);

    rra_pkg::t_state r_state;
    rra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = rra_pkg::RES_OK;
        case (r_state)
            rra_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_command == rra_pkg::CMD_FREE) ? rra_pkg::ST_FREE_CHK
                                                               : rra_pkg::ST_SCAN;
                end
            end
            rra_pkg::ST_SCAN: begin
                if (i_stat.scan_free) begin
                    n_state = i_stat.req_zero ? rra_pkg::ST_FINISH : rra_pkg::ST_PROBE;
                end else if (i_stat.scan_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.res    = rra_pkg::RES_NONE;
                    n_state      = rra_pkg::ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            rra_pkg::ST_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.probe_hit) begin
                    if (i_stat.alloc_k_last) begin
                        n_state = rra_pkg::ST_COMMIT;
                    end
                end else if (i_stat.probe_last) begin
                    // Every unit was tried: give back what this transaction took.
                    o_cmd.rollback = 1'b1;
                    o_cmd.finish   = 1'b1;
                    o_cmd.res      = rra_pkg::RES_FAIL;
                    n_state        = rra_pkg::ST_IDLE;
                end
            end
            rra_pkg::ST_COMMIT: begin
                o_cmd.mem_wr = 1'b1;
                if (i_stat.commit_last) begin
                    n_state = rra_pkg::ST_FINISH;
                end
            end
            rra_pkg::ST_FREE_CHK: begin
                if (i_stat.free_ok) begin
                    n_state = rra_pkg::ST_FREE_TAKE;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.res    = rra_pkg::RES_FAIL;
                    n_state      = rra_pkg::ST_IDLE;
                end
            end
            rra_pkg::ST_FREE_TAKE: begin
                o_cmd.free_take = 1'b1;
                n_state = i_stat.free_k_last ? rra_pkg::ST_FINISH : rra_pkg::ST_FREE_RD;
            end
            rra_pkg::ST_FREE_RD: begin
                // Wait for the registered list read.
                n_state = rra_pkg::ST_FREE_TAKE;
            end
            rra_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                o_cmd.res    = rra_pkg::RES_OK;
                n_state      = rra_pkg::ST_IDLE;
            end
            default: begin
                n_state = rra_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != rra_pkg::ST_IDLE);

endmodule

FILE: rtl/core/rra_dp.sv
// Datapath for the round-robin slot allocator: occupancy map, search pointer,
// slot counts, slot unit list memory and the result register. Depends on rra_pkg.
module rra_dp #(
    parameter int POOL_UNITS       = rra_pkg::POOL_UNITS_DEF,
    parameter int OBJECT_SLOTS     = rra_pkg::OBJECT_SLOTS_DEF,
    parameter int UNITS_PER_OBJECT = rra_pkg::UNITS_PER_OBJECT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rra_pkg::t_in                i_in,
    input  rra_pkg::t_dp_cmd            i_cmd,
    input  logic                        i_cfg_we,
    input  logic [rra_pkg::UNIT_W-1:0]  i_cfg_wdata,
    output rra_pkg::t_dp_stat           o_stat,
    output rra_pkg::t_out               o_result,
    output logic                        o_result_valid
);

    localparam int UW    = $clog2(POOL_UNITS);
    localparam int SW    = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
    localparam int KW    = (UNITS_PER_OBJECT > 1) ? $clog2(UNITS_PER_OBJECT) : 1;
    localparam int DEPTH = OBJECT_SLOTS * UNITS_PER_OBJECT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = rra_pkg::CNT_W;

    logic [rra_pkg::UNIT_W-1:0]     r_base;
    logic [POOL_UNITS-1:0]          r_busy;
    logic [POOL_UNITS-1:0]          n_busy;
    logic [UW-1:0]                  r_ptr;
    logic [UW-1:0]                  r_tries;
    logic [CW-1:0]                  r_cnt [OBJECT_SLOTS];
    logic [UW-1:0]                  r_list [DEPTH];
    logic [UW-1:0]                  r_rd_data;
    logic [UW-1:0]                  r_taken [UNITS_PER_OBJECT];
    rra_pkg::t_cmd_code             r_command;
    logic [CW-1:0]                  r_req;
    logic [rra_pkg::SLOT_IN_W-1:0]  r_slot_in;
    logic [SW-1:0]                  r_slot;
    logic [CW-1:0]                  r_k;
    logic [CW-1:0]                  r_j;
    rra_pkg::t_out                  r_result;
    rra_pkg::t_out                  n_result;
    logic                           r_valid;

    logic [UW-1:0]                  w_ptr_nxt;
    logic                           w_hit;
    logic [CW-1:0]                  w_cur_cnt;
    logic                           w_in_range;
    logic [AW-1:0]                  w_base_addr;
    logic [AW-1:0]                  w_rd_addr;
    logic [AW-1:0]                  w_wr_addr;
    logic [CW-1:0]                  w_req_sat;
    logic [rra_pkg::UNIT_W-1:0]     w_units [rra_pkg::OUT_UNITS];

    assign w_ptr_nxt  = (r_ptr == UW'(POOL_UNITS - 1)) ? '0 : r_ptr + 1'b1;
    assign w_hit      = !r_busy[w_ptr_nxt];
    assign w_cur_cnt  = r_cnt[r_slot];
    assign w_in_range = {4'b0000, r_slot_in} < 7'(OBJECT_SLOTS);
    assign w_base_addr = AW'(r_slot) * AW'(UNITS_PER_OBJECT);
    assign w_rd_addr  = w_base_addr + AW'(r_k);
    assign w_wr_addr  = w_base_addr + AW'(r_j);
    assign w_req_sat  = (i_in.unit_count > CW'(UNITS_PER_OBJECT)) ? CW'(UNITS_PER_OBJECT)
                                                                   : i_in.unit_count;

    always_comb begin
        o_stat.scan_free    = (w_cur_cnt == '0);
        o_stat.scan_last    = (r_slot == SW'(OBJECT_SLOTS - 1));
        o_stat.req_zero     = (r_req == '0);
        o_stat.probe_hit    = w_hit;
        o_stat.probe_last   = (r_tries == UW'(POOL_UNITS - 1));
        o_stat.alloc_k_last = (CW'(r_k + 1'b1) == r_req);
        o_stat.commit_last  = (CW'(r_j + 1'b1) == r_req);
        o_stat.free_ok      = w_in_range && (w_cur_cnt != '0);
        o_stat.free_k_last  = (CW'(r_k + 1'b1) == w_cur_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // Transaction registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_in.command;
            r_req     <= w_req_sat;
            r_slot_in <= i_in.slot_index;
            r_slot    <= (i_in.command == rra_pkg::CMD_FREE) ? SW'(i_in.slot_index) : '0;
            r_k       <= '0;
            r_j       <= '0;
            r_tries   <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_slot <= r_slot + 1'b1;
            end
            if (i_cmd.probe) begin
                if (w_hit) begin
                    r_taken[r_k[KW-1:0]] <= w_ptr_nxt;
                    r_k     <= r_k + 1'b1;
                    r_tries <= '0;
                end else begin
                    r_tries <= r_tries + 1'b1;
                end
            end
            if (i_cmd.free_take) begin
                r_taken[r_k[KW-1:0]] <= r_rd_data;
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.mem_wr) begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // The pointer is never rolled back, even when the allocation fails.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.probe) begin
            r_ptr <= w_ptr_nxt;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_cmd.probe && w_hit) begin
            n_busy[w_ptr_nxt] = 1'b1;
        end
        if (i_cmd.rollback) begin
            for (int r = 0; r < UNITS_PER_OBJECT; r++) begin
                if (CW'(r) < r_k) begin
                    n_busy[r_taken[r]] = 1'b0;
                end
            end
        end
        if (i_cmd.free_take && ({1'b0, r_rd_data} < (UW + 1)'(POOL_UNITS))) begin
            n_busy[r_rd_data] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < OBJECT_SLOTS; s++) begin
                r_cnt[s] <= '0;
            end
        end else if (i_cmd.finish && (i_cmd.res == rra_pkg::RES_OK)) begin
            r_cnt[r_slot] <= (r_command == rra_pkg::CMD_FREE) ? '0 : r_req;
        end
    end

    // Slot unit list: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_list[w_wr_addr] <= r_taken[r_j[KW-1:0]];
        end
        r_rd_data <= r_list[w_rd_addr];
    end

    always_comb begin
        for (int x = 0; x < rra_pkg::OUT_UNITS; x++) begin
            w_units[x] = '0;
        end
        for (int x = 0; x < UNITS_PER_OBJECT; x++) begin
            if (CW'(x) < r_k) begin
                w_units[x] = rra_pkg::UNIT_W'(r_taken[x]) + r_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_comb begin
        n_result = '0;
        if (r_command == rra_pkg::CMD_FREE) begin
            n_result.slot_number = r_slot_in;
        end else if (i_cmd.res != rra_pkg::RES_NONE) begin
            n_result.slot_number = rra_pkg::SLOT_IN_W'(r_slot);
        end
        if (i_cmd.res == rra_pkg::RES_OK) begin
            n_result.success     = 1'b1;
            n_result.units_valid = r_k;
            n_result.unit_a      = w_units[0];
            n_result.unit_b      = w_units[1];
            n_result.unit_c      = w_units[2];
            n_result.unit_d      = w_units[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_valid;

endmodule

FILE: rtl/core/multi_slot_round_robin_allocator_top.sv
// Round-robin two-level slot allocator. A granted allocate scans for the lowest free slot,
// probes the pool for units, one probe per cycle, and writes one list entry per unit before
// the strobe; a failed unit search or a search that finds no free slot ends in a refusal.
// A free reads the slot's units back from the list memory, one read per unit; a free of an empty slot fails.
// One command at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous reset frees every slot and unit and clears the pointer and unit_base.
module multi_slot_round_robin_allocator_top #(
    parameter int POOL_UNITS       = rra_pkg::POOL_UNITS_DEF,
    parameter int OBJECT_SLOTS     = rra_pkg::OBJECT_SLOTS_DEF,
    parameter int UNITS_PER_OBJECT = rra_pkg::UNITS_PER_OBJECT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rra_pkg::t_in                i_in,
    output rra_pkg::t_out               o_result,
    output logic                        o_result_valid,
    input  logic                        i_cfg_we,
    input  logic [rra_pkg::UNIT_W-1:0]  i_cfg_wdata
);

    rra_pkg::t_dp_cmd  w_cmd;
    rra_pkg::t_dp_stat w_stat;

    rra_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_in.command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    rra_dp #(
        .POOL_UNITS       (POOL_UNITS),
        .OBJECT_SLOTS     (OBJECT_SLOTS),
        .UNITS_PER_OBJECT (UNITS_PER_OBJECT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_stat         (w_stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

FILE: bench/multi_slot_round_robin_allocator_top_test.sv
// Self-checking bench for the round-robin slot allocator: directed and random command
// traffic, predicted results compared field by field. Depends on rra_pkg and the top.
`timescale 1ns / 100ps

module multi_slot_round_robin_allocator_top_test;

    localparam int QUIET_LIMIT          = 2000;
    localparam int UNIT_W               = rra_pkg::UNIT_W;
    localparam int CNT_W                = rra_pkg::CNT_W;
    localparam int SLOT_IN_W            = rra_pkg::SLOT_IN_W;
    localparam int OUT_UNITS            = rra_pkg::OUT_UNITS;
    localparam int POOL_UNITS_DEF       = rra_pkg::POOL_UNITS_DEF;
    localparam int OBJECT_SLOTS_DEF     = rra_pkg::OBJECT_SLOTS_DEF;
    localparam int UNITS_PER_OBJECT_DEF = rra_pkg::UNITS_PER_OBJECT_DEF;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    rra_pkg::t_in      i_in;
    rra_pkg::t_out     o_result;
    logic              o_result_valid;
    logic              i_cfg_we;
    logic [UNIT_W-1:0] i_cfg_wdata;

    multi_slot_round_robin_allocator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (i_in),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Shadow copy of the allocator state.
    logic              pool_taken [POOL_UNITS_DEF];
    logic [3:0]        probe_ptr;
    logic [CNT_W-1:0]  held_count [OBJECT_SLOTS_DEF];
    logic [3:0]        held_units [OBJECT_SLOTS_DEF][UNITS_PER_OBJECT_DEF];
    logic [UNIT_W-1:0] base_offset;

    rra_pkg::t_out awaited_results [$];
    int   mismatch_count;
    int   sent_count;
    int   grants_seen;
    int   refusals_seen;
    int   releases_seen;
    int   quiet_cycles;

    function automatic rra_pkg::t_out allocator_outcome(rra_pkg::t_in item);
        rra_pkg::t_out     res;
        logic [UNIT_W-1:0] nums [OUT_UNITS];
        logic [3:0]        claimed [UNITS_PER_OBJECT_DEF];
        int                slot;
        int                want;
        int                got;
        int                k;
        int                t;
        logic              hit;
        res = '0;
        for (k = 0; k < OUT_UNITS; k++) nums[k] = '0;
        if (item.command == rra_pkg::CMD_FREE) begin
            res.slot_number = item.slot_index;
            if (held_count[item.slot_index] != 0) begin
                for (k = 0; k < held_count[item.slot_index]; k++) begin
                    pool_taken[held_units[item.slot_index][k]] = 1'b0;
                    nums[k] = base_offset + UNIT_W'(held_units[item.slot_index][k]);
                end
                res.success = 1'b1;
                res.units_valid = held_count[item.slot_index];
                held_count[item.slot_index] = '0;
                releases_seen++;
            end
        end else begin
            slot = -1;
            for (k = OBJECT_SLOTS_DEF - 1; k >= 0; k--)
                if (held_count[k] == 0) slot = k;
            if (slot < 0) begin
                refusals_seen++;
            end else begin
                res.slot_number = SLOT_IN_W'(slot);
                want = (item.unit_count > UNITS_PER_OBJECT_DEF) ?
                       UNITS_PER_OBJECT_DEF : int'(item.unit_count);
                got = 0;
                hit = 1'b1;
                while (got < want && hit) begin
                    hit = 1'b0;
                    // The pointer moves before every probe and keeps its advance on failure.
                    for (t = 0; t < POOL_UNITS_DEF && !hit; t++) begin
                        probe_ptr = (probe_ptr == POOL_UNITS_DEF - 1) ? '0 : probe_ptr + 1'b1;
                        if (!pool_taken[probe_ptr]) begin
                            pool_taken[probe_ptr] = 1'b1;
                            claimed[got] = probe_ptr;
                            got++;
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    for (k = 0; k < want; k++) begin
                        held_units[slot][k] = claimed[k];
                        nums[k] = base_offset + UNIT_W'(claimed[k]);
                    end
                    held_count[slot] = CNT_W'(want);
                    res.success = 1'b1;
                    res.units_valid = CNT_W'(want);
                    grants_seen++;
                end else begin
                    for (k = 0; k < got; k++) pool_taken[claimed[k]] = 1'b0;
                    refusals_seen++;
                end
            end
        end
        res.unit_a = nums[0];
        res.unit_b = nums[1];
        res.unit_c = nums[2];
        res.unit_d = nums[3];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Result checker: the strobe cannot be held off, so every strobed cycle is a transaction.
    always @(posedge i_clk) begin
        rra_pkg::t_out want;
        if (i_rst_n && o_result_valid) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, success", o_result.success, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_result.success !== want.success)
                    report_mismatch("success", o_result.success, want.success);
                if (o_result.slot_number !== want.slot_number)
                    report_mismatch("slot_number", o_result.slot_number, want.slot_number);
                if (o_result.units_valid !== want.units_valid)
                    report_mismatch("units_valid", o_result.units_valid, want.units_valid);
                if (o_result.unit_a !== want.unit_a)
                    report_mismatch("unit_a", o_result.unit_a, want.unit_a);
                if (o_result.unit_b !== want.unit_b)
                    report_mismatch("unit_b", o_result.unit_b, want.unit_b);
                if (o_result.unit_c !== want.unit_c)
                    report_mismatch("unit_c", o_result.unit_c, want.unit_c);
                if (o_result.unit_d !== want.unit_d)
                    report_mismatch("unit_d", o_result.unit_d, want.unit_d);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
                $display("multi_slot_round_robin_allocator_top test failed");
                $finish;
            end
        end
    end

    // Leaves start high on return; the caller either sends again or lowers it.
    task automatic send_command(rra_pkg::t_cmd_code cmd, int count, int slot);
        rra_pkg::t_in item;
        item.command = cmd;
        item.unit_count = CNT_W'(count);
        item.slot_index = SLOT_IN_W'(slot);
        start <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (busy);
        awaited_results.push_back(allocator_outcome(item));
        sent_count++;
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_unit_base(logic [UNIT_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_offset = value;
        @(posedge i_clk);
    endtask

    task automatic test_empty_free_and_zero_count();
        set_unit_base('0);
        send_command(rra_pkg::CMD_FREE, 0, 7);
        send_command(rra_pkg::CMD_ALLOC, 0, 0);
        start <= 1'b0;
    endtask

    // Counts above four saturate; four full grants use up the whole pool.
    task automatic test_pool_exhaustion();
        send_command(rra_pkg::CMD_ALLOC, 4, 0);
        send_command(rra_pkg::CMD_ALLOC, 5, 2);
        send_command(rra_pkg::CMD_ALLOC, 6, 4);
        send_command(rra_pkg::CMD_ALLOC, 7, 6);
        send_command(rra_pkg::CMD_ALLOC, 2, 0);
        send_command(rra_pkg::CMD_FREE, 1, 1);
        send_command(rra_pkg::CMD_ALLOC, 3, 0);
        // Takes one unit, then finds the pool empty and hands it back.
        send_command(rra_pkg::CMD_ALLOC, 3, 0);
        start <= 1'b0;
    endtask

    task automatic test_slot_exhaustion();
        send_command(rra_pkg::CMD_FREE, 2, 0);
        send_command(rra_pkg::CMD_FREE, 2, 2);
        send_command(rra_pkg::CMD_FREE, 2, 3);
        repeat (7) send_command(rra_pkg::CMD_ALLOC, 1, 5);
        send_command(rra_pkg::CMD_ALLOC, 2, 1);
        send_command(rra_pkg::CMD_ALLOC, 0, 1);
        start <= 1'b0;
    endtask

    // Mostly allocates and frees of held slots; a tenth is arbitrary noise.
    task automatic test_random_traffic(int items, int idle_pct, logic [UNIT_W-1:0] base);
        int                 pick;
        int                 count;
        int                 slot;
        int                 tries;
        rra_pkg::t_cmd_code cmd;
        set_unit_base(base);
        repeat (items) begin
            pick = $urandom_range(0, 99);
            count = $urandom_range(1, 4);
            slot = $urandom_range(0, OBJECT_SLOTS_DEF - 1);
            if (pick < 10) begin
                cmd = (pick < 5) ? rra_pkg::CMD_ALLOC : rra_pkg::CMD_FREE;
                count = $urandom_range(0, 7);
            end else if (pick < 55) begin
                cmd = rra_pkg::CMD_ALLOC;
            end else begin
                cmd = rra_pkg::CMD_FREE;
                tries = 0;
                while (held_count[slot] == 0 && tries < 8) begin
                    slot = $urandom_range(0, OBJECT_SLOTS_DEF - 1);
                    tries++;
                end
            end
            send_command(cmd, count, slot);
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        mismatch_count = 0;
        sent_count = 0;
        grants_seen = 0;
        refusals_seen = 0;
        releases_seen = 0;
        probe_ptr = '0;
        base_offset = '0;
        for (int k = 0; k < POOL_UNITS_DEF; k++) pool_taken[k] = 1'b0;
        for (int k = 0; k < OBJECT_SLOTS_DEF; k++) held_count[k] = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_free_and_zero_count();
        test_pool_exhaustion();
        test_slot_exhaustion();
        test_random_traffic(110, 0, 6'd39);
        test_random_traffic(110, 54, 6'd24);
        // A base of 63 makes every reported unit number above zero wrap.
        test_random_traffic(110, 18, 6'd63);
        test_random_traffic(110, 0, 6'($urandom_range(0, 39)));
        test_random_traffic(110, 54, 6'd0);

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", 0, awaited_results.size());

        $display("Sent %0d commands: %0d grants, %0d refused allocations, %0d releases.",
                 sent_count, grants_seen, refusals_seen, releases_seen);
        $display("Unit base settings 0, 39, 24, 63 and random; sender idle 0, 18, 54 pct.");
        if (mismatch_count == 0) begin
            $display("multi_slot_round_robin_allocator_top test passed");
        end else begin
            $display("multi_slot_round_robin_allocator_top test failed");
        end
        $finish;
    end

endmodule
